[rtl/ipt_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ipt_pkg
// Shared types and constants for the inverted page table with lru replacement.
// ----------------------------------------------------------------------------
package ipt_pkg;

	localparam int unsigned ENTRIES_DEF   = 128;
	localparam int unsigned PAGE_BITS_DEF = 10;

	localparam int unsigned PROC_W  = 16;
	localparam int unsigned PAGE_W  = 20;
	localparam int unsigned ADDR_W  = 32;
	localparam int unsigned TIME_W  = 32;
	localparam int unsigned PHYS_W  = 17;
	localparam int unsigned FRAME_W = 7;

	localparam logic OP_TRANSLATE = 1'b0;
	localparam logic OP_LOAD      = 1'b1;

	typedef struct packed {
		logic              op;
		logic [PROC_W-1:0] proc_id;
		logic [PAGE_W-1:0] page_number;
		logic [ADDR_W-1:0] virtual_address;
		logic [TIME_W-1:0] now_time;
	} req_word_t;

	typedef struct packed {
		logic               found;
		logic [PHYS_W-1:0]  physical_address;
		logic [FRAME_W-1:0] frame_index;
		logic               evicted;
		logic [PROC_W-1:0]  victim_proc_id;
		logic [PAGE_W-1:0]  victim_page;
	} rsp_word_t;

	// one table word as held in memory
	typedef struct packed {
		logic [PROC_W-1:0] proc_id;
		logic [PAGE_W-1:0] page;
		logic [TIME_W-1:0] atime;
	} entry_t;

	localparam int unsigned ENTRY_W = $bits(entry_t);

endpackage

`default_nettype wire

[rtl/inverted_page_table_lru.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// inverted_page_table_lru
// Inverted page table with least recently used replacement.
// ----------------------------------------------------------------------------
// The table lives in one synchronous memory, one word per frame, read one
// entry per cycle. Valid entries always form a block from frame 0 up, kept
// as a fill count, so reset needs no clearing pass. A load into a free frame
// writes the next free word without a scan. A translate scans the valid
// entries until a hit, or all of them on a miss; an empty table answers a
// miss without a scan. A load into a full table scans every entry for the
// oldest time. A finished word sits in an output register, so the next
// request is taken while the last result waits on rsp_ready.
module inverted_page_table_lru #(
	parameter int unsigned ENTRIES   = ipt_pkg::ENTRIES_DEF,
	parameter int unsigned PAGE_BITS = ipt_pkg::PAGE_BITS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               req_valid,
	output      logic               req_ready,
	input  wire ipt_pkg::req_word_t req,
	output      logic               rsp_valid,
	input  wire logic               rsp_ready,
	output      ipt_pkg::rsp_word_t rsp
);
	import ipt_pkg::*;

	localparam int unsigned IDX_W = $clog2(ENTRIES);

	logic             res_valid;
	rsp_word_t        res;
	logic             res_take;
	logic             mem_we;
	logic [IDX_W-1:0] mem_waddr;
	entry_t           mem_wdata;
	logic             mem_re;
	logic [IDX_W-1:0] mem_raddr;
	entry_t           mem_rdata;
	logic             rsp_valid_q;
	rsp_word_t        rsp_q;

	ipt_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (ENTRIES)
	) u_table (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	ipt_ctrl #(
		.ENTRIES   (ENTRIES),
		.PAGE_BITS (PAGE_BITS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.res_valid (res_valid),
		.res       (res),
		.res_take  (res_take),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	// output word register, refilled as it drains
	assign res_take  = res_valid && (!rsp_valid_q || rsp_ready);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_take) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			rsp_q <= res;
		end
	end

endmodule

`default_nettype wire

[rtl/ipt_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ipt_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module ipt_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

[rtl/ipt_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ipt_ctrl
// Request sequencer: scans the table memory one entry per cycle for a hit or
// the oldest entry and writes the entry back; a free-frame load needs no scan.
// ----------------------------------------------------------------------------
module ipt_ctrl #(
	parameter int unsigned ENTRIES   = ipt_pkg::ENTRIES_DEF,
	parameter int unsigned PAGE_BITS = ipt_pkg::PAGE_BITS_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       req_valid,
	output      logic                       req_ready,
	input  wire ipt_pkg::req_word_t         req,
	output      logic                       res_valid,
	output      ipt_pkg::rsp_word_t         res,
	input  wire logic                       res_take,
	output      logic                       mem_we,
	output      logic [$clog2(ENTRIES)-1:0] mem_waddr,
	output      ipt_pkg::entry_t            mem_wdata,
	output      logic                       mem_re,
	output      logic [$clog2(ENTRIES)-1:0] mem_raddr,
	input  wire ipt_pkg::entry_t            mem_rdata
);
	import ipt_pkg::*;

	localparam int unsigned IDX_W = $clog2(ENTRIES);
	localparam int unsigned CNT_W = $clog2(ENTRIES + 1);
	localparam logic [CNT_W-1:0] FULL = CNT_W'(ENTRIES);
	localparam logic [ADDR_W-1:0] OFF_MASK = ADDR_W'((64'd1 << PAGE_BITS) - 64'd1);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_START = 2'd1;
	localparam logic [1:0] ST_SCAN  = 2'd2;
	localparam logic [1:0] ST_DONE  = 2'd3;

	logic [1:0]       state_q, state_d;
	req_word_t        req_q;
	logic [CNT_W-1:0] fill_q;      // entries 0 .. fill_q-1 are valid
	logic [CNT_W-1:0] addr_q;
	logic             rd_valid_s1;
	logic             rd_last_s1;
	logic [IDX_W-1:0] rd_idx_s1;
	entry_t           min_q;
	logic [IDX_W-1:0] min_idx_q;
	rsp_word_t        res_q, res_d;
	logic             res_load;
	logic             fill_inc;

	logic             hit;
	logic             better;
	entry_t           win;
	logic [IDX_W-1:0] win_idx;
	logic [ADDR_W-1:0] phys_full;

	assign req_ready = (state_q == ST_IDLE);
	assign res_valid = (state_q == ST_DONE);
	assign res       = res_q;

	assign mem_re    = (state_q == ST_SCAN) && (addr_q < fill_q);
	assign mem_raddr = addr_q[IDX_W-1:0];

	assign hit = (mem_rdata.proc_id == req_q.proc_id) && (mem_rdata.page == req_q.page_number);
	// strict less keeps the lowest index on equal times
	assign better  = (rd_idx_s1 == '0) || (mem_rdata.atime < min_q.atime);
	assign win     = better ? mem_rdata : min_q;
	assign win_idx = better ? rd_idx_s1 : min_idx_q;
	assign phys_full = (ADDR_W'(rd_idx_s1) << PAGE_BITS) | (req_q.virtual_address & OFF_MASK);

	always_comb begin
		state_d   = state_q;
		mem_we    = 1'b0;
		mem_waddr = rd_idx_s1;
		mem_wdata = '{proc_id: req_q.proc_id, page: req_q.page_number, atime: req_q.now_time};
		res_d     = '0;
		res_load  = 1'b0;
		fill_inc  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					state_d = ST_START;
				end
			end
			ST_START: begin
				if (req_q.op == OP_TRANSLATE) begin
					if (fill_q == '0) begin
						res_load = 1'b1;
						state_d  = ST_DONE;
					end else begin
						state_d = ST_SCAN;
					end
				end else if (fill_q != FULL) begin
					mem_we            = 1'b1;
					mem_waddr         = fill_q[IDX_W-1:0];
					fill_inc          = 1'b1;
					res_d.found       = 1'b1;
					res_d.frame_index = FRAME_W'(fill_q[IDX_W-1:0]);
					res_load          = 1'b1;
					state_d           = ST_DONE;
				end else begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (rd_valid_s1) begin
					if (req_q.op == OP_TRANSLATE) begin
						if (hit) begin
							mem_we                 = 1'b1;
							mem_waddr              = rd_idx_s1;
							res_d.found            = 1'b1;
							res_d.frame_index      = FRAME_W'(rd_idx_s1);
							res_d.physical_address = phys_full[PHYS_W-1:0];
							res_load               = 1'b1;
							state_d                = ST_DONE;
						end else if (rd_last_s1) begin
							res_load = 1'b1;
							state_d  = ST_DONE;
						end
					end else if (rd_last_s1) begin
						mem_we               = 1'b1;
						mem_waddr            = win_idx;
						res_d.found          = 1'b1;
						res_d.frame_index    = FRAME_W'(win_idx);
						res_d.evicted        = 1'b1;
						res_d.victim_proc_id = win.proc_id;
						res_d.victim_page    = win.page;
						res_load             = 1'b1;
						state_d              = ST_DONE;
					end
				end
			end
			ST_DONE: begin
				if (res_take) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fill_q      <= '0;
			addr_q      <= '0;
			rd_valid_s1 <= 1'b0;
		end else begin
			state_q     <= state_d;
			rd_valid_s1 <= mem_re;
			if (fill_inc) begin
				fill_q <= fill_q + CNT_W'(1);
			end
			if (state_q == ST_START) begin
				addr_q <= '0;
			end else if (mem_re) begin
				addr_q <= addr_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			req_q <= req;
		end
		if (mem_re) begin
			rd_idx_s1  <= mem_raddr;
			rd_last_s1 <= (addr_q == fill_q - CNT_W'(1));
		end
		if ((state_q == ST_SCAN) && rd_valid_s1) begin
			min_q     <= win;
			min_idx_q <= win_idx;
		end
		if (res_load) begin
			res_q <= res_d;
		end
	end

endmodule

`default_nettype wire
